// ===== rtl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, codes and character helpers for the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

  localparam int MAX_BUFFER_BYTES = 65535;
  localparam int POS_CAP_INT      = (MAX_BUFFER_BYTES > 65535) ? 65535 : MAX_BUFFER_BYTES;
  localparam logic [15:0] POS_CAP = 16'(POS_CAP_INT);

  // scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_WORD   = 2'd2;
  localparam logic [1:0] MODE_NUMBER = 2'd3;

  // token kinds
  localparam logic [2:0] KIND_NEWLINE = 3'd0;
  localparam logic [2:0] KIND_EOF     = 3'd1;
  localparam logic [2:0] KIND_PRINT   = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_ADD     = 3'd4;
  localparam logic [2:0] KIND_MULT    = 3'd5;
  localparam logic [2:0] KIND_NUMBER  = 3'd6;
  localparam logic [2:0] KIND_WORD    = 3'd7;

  // input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOB  = 1'b1;

  // characters
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CASE_MASK  = 8'hDF;
  localparam logic [15:0] KW_LEN    = 16'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        eol;
  } bst_tok_t;

  // up to two tokens from one transaction, first before second
  typedef struct packed {
    logic     va;
    bst_tok_t a;
    logic     vb;
    bst_tok_t b;
  } bst_push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] p);
    return (p >= POS_CAP) ? POS_CAP : p + 16'd1;
  endfunction

  // keyword text, upper case
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h50;
      3'd1:    ch = 8'h52;
      3'd2:    ch = 8'h49;
      3'd3:    ch = 8'h4E;
      3'd4:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bst_scan.sv =====
// ----------------------------------------------------------------------------
// bst_scan
// Scanner state and per-byte decode; produces up to two tokens per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_scan (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               cmd,
  input  wire logic [7:0]         src,
  output bst_pkg::bst_push_t      push
);
  import bst_pkg::*;

  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] start_r, start_nxt;
  logic        kw_r, kw_nxt;

  logic [15:0] open_len;
  logic [7:0]  upper;
  logic        c_alpha, c_digit;
  bst_tok_t    close_tok;
  logic        do_idle;

  assign open_len = (pos_r >= start_r) ? pos_r - start_r : 16'd0;
  assign upper    = src & CASE_MASK;
  assign c_alpha  = is_alpha(src);
  assign c_digit  = is_digit(src);

  always_comb begin
    close_tok.start  = start_r;
    close_tok.length = open_len;
    close_tok.eol    = 1'b0;
    case (mode_r)
      MODE_STRING: close_tok.kind = KIND_STRING;
      MODE_WORD:   close_tok.kind = (kw_r && open_len == KW_LEN) ? KIND_PRINT : KIND_WORD;
      MODE_NUMBER: close_tok.kind = KIND_NUMBER;
      default:     close_tok.kind = KIND_WORD;
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    kw_nxt    = kw_r;
    push      = '0;
    do_idle   = 1'b0;
    push.a    = close_tok;
    if (adv) begin
      if (cmd == CMD_EOB) begin
        push.va       = (mode_r != MODE_IDLE);
        push.vb       = 1'b1;
        push.b.kind   = KIND_EOF;
        push.b.start  = pos_r;
        push.b.length = 16'd0;
        push.b.eol    = 1'b1;
        mode_nxt      = MODE_IDLE;
        pos_nxt       = 16'd0;
        start_nxt     = 16'd0;
        kw_nxt        = 1'b0;
      end else begin
        pos_nxt = sat_inc(pos_r);
        case (mode_r)
          MODE_STRING: begin
            if (src == CH_QUOTE) begin
              push.va  = 1'b1;
              mode_nxt = MODE_IDLE;
              kw_nxt   = 1'b0;
            end
          end
          MODE_WORD: begin
            if (c_alpha || c_digit || src == CH_UNDER) begin
              if (open_len < KW_LEN) begin
                kw_nxt = kw_r && (upper == kw_char(open_len[2:0]));
              end else begin
                kw_nxt = 1'b0;
              end
            end else begin
              push.va  = 1'b1;
              mode_nxt = MODE_IDLE;
              kw_nxt   = 1'b0;
              do_idle  = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (!c_digit) begin
              push.va  = 1'b1;
              mode_nxt = MODE_IDLE;
              kw_nxt   = 1'b0;
              do_idle  = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // the byte as seen with no token open
        if (do_idle) begin
          push.b.start  = pos_r;
          push.b.length = 16'd1;
          push.b.eol    = 1'b0;
          if (src == CH_QUOTE) begin
            mode_nxt  = MODE_STRING;
            start_nxt = sat_inc(pos_r);
          end else if (c_alpha) begin
            mode_nxt  = MODE_WORD;
            start_nxt = pos_r;
            kw_nxt    = (upper == kw_char(3'd0));
          end else if (c_digit) begin
            mode_nxt  = MODE_NUMBER;
            start_nxt = pos_r;
          end else if (src == CH_STAR) begin
            push.vb     = 1'b1;
            push.b.kind = KIND_MULT;
          end else if (src == CH_PLUS) begin
            push.vb     = 1'b1;
            push.b.kind = KIND_ADD;
          end else if (src == CH_NL) begin
            push.vb     = 1'b1;
            push.b.kind = KIND_NEWLINE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= 16'd0;
      start_r <= 16'd0;
      kw_r    <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bst_fifo.sv =====
// ----------------------------------------------------------------------------
// bst_fifo
// Four-entry token queue: up to two tokens in a cycle, one out on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire bst_pkg::bst_push_t push,
  output logic                    room2,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bst_pkg::bst_tok_t       out_tok
);
  import bst_pkg::*;

  bst_tok_t    mem_r [4];
  logic [1:0]  wp_r, wp_nxt;
  logic [1:0]  rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;
  logic        wa, wb;
  logic [1:0]  wb_addr;

  assign room2     = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_tok   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign wa        = adv && push.va;
  assign wb        = adv && push.vb;
  assign wb_addr   = wp_r + {1'b0, wa};

  assign wp_nxt  = wp_r + {1'b0, wa} + {1'b0, wb};
  assign rp_nxt  = rp_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {2'b00, wa} + {2'b00, wb} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (wa) begin
      mem_r[wp_r] <= push.a;
    end
    if (wb) begin
      mem_r[wb_addr] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/basic_source_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// basic_source_tokenizer_top
// Streaming source tokenizer: bytes in, kind/offset/length tokens out.
// ----------------------------------------------------------------------------
// order: the first token of a transaction passes the input register, then
//   the token queue, before it shows on out_valid
// throughput: one input transaction per cycle while the four-entry token
//   queue has two free entries; one token per cycle drains on out_ready
// reset: synchronous rst_n clears scan state, byte offset and the queue
`default_nettype none

module basic_source_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_source_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_end_of_list
);
  import bst_pkg::*;

  logic       in_v_r, in_v_nxt;
  logic       cmd_r;
  logic [7:0] byte_r;
  logic       adv;
  logic       room2;
  bst_push_t  push;
  bst_tok_t   out_tok;

  assign adv      = in_v_r && room2;
  assign in_ready = !in_v_r || adv;
  assign in_v_nxt = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      byte_r <= in_source_byte;
    end
  end

  bst_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cmd   (cmd_r),
    .src   (byte_r),
    .push  (push)
  );

  bst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_token_start  = out_tok.start;
  assign out_token_length = out_tok.length;
  assign out_end_of_list  = out_tok.eol;

endmodule

`default_nettype wire

// ===== rtl/bst_checker.sv =====
// ----------------------------------------------------------------------------
// bst_checker
// Port-level assertions for the source tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_token_kind,
  input  wire logic [15:0] out_token_start,
  input  wire logic [15:0] out_token_length,
  input  wire logic        out_end_of_list
);
  import bst_pkg::*;

  // end of list marks exactly the eof token, which has no text
  a_eol_is_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_of_list == (out_token_kind == KIND_EOF)) &&
                  (!out_end_of_list || out_token_length == 16'd0))
    else $error("eol flag does not match eof token");

  // single-byte tokens have length one
  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_NEWLINE || out_token_kind == KIND_ADD ||
                  out_token_kind == KIND_MULT) |-> out_token_length == 16'd1)
    else $error("single-byte token with wrong length");

  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token output valid right after reset");

  // stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
      $stable(out_token_start) && $stable(out_token_length) && $stable(out_end_of_list))
    else $error("stalled token changed");

  // an offered input transaction stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before acceptance");

endmodule

bind basic_source_tokenizer_top bst_checker u_bst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_token_start  (out_token_start),
  .out_token_length (out_token_length),
  .out_end_of_list  (out_end_of_list)
);

`default_nettype wire
